>>> rtl/pfc_pkg.sv
// Shared types, constants and helper functions for the Playfair digraph cipher.
`timescale 1ns / 1ps

package pfc_pkg;

  localparam int unsigned LetterW    = 5;
  localparam int unsigned SqSide     = 5;
  localparam int unsigned SqCells    = SqSide * SqSide;
  localparam int unsigned NumLetters = 26;
  localparam int unsigned RcW        = 3;
  localparam int unsigned QDepth     = 2;
  localparam int unsigned QPtrW      = $clog2(QDepth);
  localparam int unsigned QCntW      = $clog2(QDepth + 1);

  localparam logic [LetterW-1:0] CodeI = LetterW'(8);
  localparam logic [LetterW-1:0] CodeJ = LetterW'(9);
  localparam logic [LetterW-1:0] CodeZ = LetterW'(25);
  localparam logic [RcW-1:0]     RcLast = RcW'(SqSide - 1);

  // request kind codes on the input port
  localparam logic [1:0] KindKey     = 2'd0;
  localparam logic [1:0] KindFinish  = 2'd1;
  localparam logic [1:0] KindDigraph = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [LetterW-1:0] letter_a;
    logic [LetterW-1:0] letter_b;
  } in_req_t;

  typedef struct packed {
    logic [LetterW-1:0] cipher_a;
    logic [LetterW-1:0] cipher_b;
    logic               status;
  } out_rsp_t;

  typedef enum logic [1:0] {
    OP_KEY,
    OP_FINISH,
    OP_DIGRAPH
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [LetterW-1:0] a;
    logic [LetterW-1:0] b;
  } cmd_t;

  // head of the front queue as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  // row/column of a placed letter
  typedef struct packed {
    logic [RcW-1:0] row;
    logic [RcW-1:0] col;
  } pos_t;

  function automatic logic [LetterW-1:0] norm_letter(input logic [LetterW-1:0] v);
    logic [LetterW-1:0] c;
    c = (v > CodeZ) ? CodeZ : v;
    if (c == CodeJ) c = CodeI;
    return c;
  endfunction

  function automatic logic [RcW-1:0] rc_next(input logic [RcW-1:0] x);
    return (x == RcLast) ? '0 : x + RcW'(1);
  endfunction

  // row * 5 + col
  function automatic logic [LetterW-1:0] cell_idx(input logic [RcW-1:0] r,
                                                  input logic [RcW-1:0] c);
    return {r, 2'b00} + LetterW'(r) + LetterW'(c);
  endfunction

endpackage

>>> rtl/playfair_digraph_cipher.sv
// Top level of the Playfair digraph cipher: front queue plus execution back end.
`timescale 1ns / 1ps

// Usage:
//   Input channel (push/full, req_i): key letters (kind 0), one finish request
//   (kind 1), then digraphs (kind 2). Letters are 0..25; J folds to I, codes
//   above 25 read as Z. Kind 3 is taken and dropped.
//   Result channel (empty/pop, rsp_o): one result per digraph, in order.
//   The oldest result sits on rsp_o while empty is low.
//   Timing: a two-entry queue decouples the sides. Key letters retire straight
//   from idle. Finish walks the alphabet one letter per cycle. A digraph passes
//   a position memory read, a square memory read and a result load in turn;
//   the back end takes no new request until that result is loaded.
//   A digraph before finish returns status 1 with zero letters.
//   Reset clears the key square state; a new key needs a reset.
//   When the receiver stalls, the result register holds, the back end waits
//   with its next result ready, and the queue fills until full rises.

module playfair_digraph_cipher import pfc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  in_req_t  req_i,
  output logic     empty,
  input  logic     pop,
  output out_rsp_t rsp_o
);

  q_head_t head;
  logic    deq;

  pfc_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .req_i  (req_i),
    .head_o (head),
    .deq_i  (deq)
  );

  pfc_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .deq_o  (deq),
    .empty  (empty),
    .pop    (pop),
    .rsp_o  (rsp_o)
  );

endmodule

>>> rtl/pfc_front.sv
// Front end: letter folding, request classification and a short command queue.
`timescale 1ns / 1ps

module pfc_front import pfc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push,
  output logic    full,
  input  in_req_t req_i,
  output q_head_t head_o,
  input  logic    deq_i
);

  cmd_t             q_mem [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             accept, enq, deq, known;
  cmd_t             cmd;

  assign full   = (cnt_q == QCntW'(QDepth));
  assign accept = push && !full;

  always_comb begin
    known = 1'b1;
    cmd.a = norm_letter(req_i.letter_a);
    cmd.b = norm_letter(req_i.letter_b);
    unique case (req_i.kind)
      KindKey:     cmd.op = OP_KEY;
      KindFinish:  cmd.op = OP_FINISH;
      KindDigraph: cmd.op = OP_DIGRAPH;
      default: begin
        // unknown kind: taken and dropped here
        cmd.op = OP_KEY;
        known  = 1'b0;
      end
    endcase
  end

  assign enq = accept && known;
  assign deq = deq_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (enq) wr_ptr_d = wr_ptr_q + QPtrW'(1);
    if (deq) rd_ptr_d = rd_ptr_q + QPtrW'(1);
    if (enq && !deq) cnt_d = cnt_q + QCntW'(1);
    else if (!enq && deq) cnt_d = cnt_q - QCntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) q_mem[wr_ptr_q] <= cmd;
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = q_mem[rd_ptr_q];

endmodule

>>> rtl/pfc_back.sv
// Back end: key square build, square fill, digraph lookups and the result register.
`timescale 1ns / 1ps

module pfc_back import pfc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  q_head_t  head_i,
  output logic     deq_o,
  output logic     empty,
  input  logic     pop,
  output out_rsp_t rsp_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_FILL = 4'b0010,
    S_POS  = 4'b0100,
    S_SQ   = 4'b1000
  } state_e;

  state_e               st_q, st_d;
  logic [NumLetters-1:0] used_q, used_d;
  logic [LetterW-1:0]   fill_q, fill_d;
  logic [RcW-1:0]       row_q, row_d, col_q, col_d;
  logic [LetterW-1:0]   fill_ltr_q, fill_ltr_d;
  logic                 ready_q, ready_d;
  logic                 out_valid_q, out_valid_d;
  out_rsp_t             rsp_q, out_d;

  logic [LetterW-1:0]   sq_mem  [SqCells];
  pos_t                 pos_mem [NumLetters];
  pos_t                 pa_q, pb_q;
  logic [LetterW-1:0]   sqa_q, sqb_q;

  logic                 place_en, place_ok, pos_rd, sq_rd, out_load, out_free;
  logic [LetterW-1:0]   place_chr, oa, ob;
  pos_t                 cur_pos;

  assign out_free = !out_valid_q || pop;
  assign cur_pos  = '{row: row_q, col: col_q};
  assign place_ok = place_en && !used_q[place_chr] && (fill_q < LetterW'(SqCells));

  always_comb begin
    st_d       = st_q;
    deq_o      = 1'b0;
    place_en   = 1'b0;
    place_chr  = head_i.cmd.a;
    pos_rd     = 1'b0;
    sq_rd      = 1'b0;
    out_load   = 1'b0;
    out_d      = '{cipher_a: sqa_q, cipher_b: sqb_q, status: 1'b0};
    fill_ltr_d = fill_ltr_q;
    ready_d    = ready_q;
    unique case (st_q)
      S_IDLE: begin
        if (head_i.valid) begin
          unique case (head_i.cmd.op)
            OP_KEY: begin
              deq_o    = 1'b1;
              place_en = !ready_q;
            end
            OP_FINISH: begin
              deq_o = 1'b1;
              if (!ready_q) begin
                fill_ltr_d = '0;
                st_d       = S_FILL;
              end
            end
            OP_DIGRAPH: begin
              if (ready_q) begin
                deq_o  = 1'b1;
                pos_rd = 1'b1;
                st_d   = S_POS;
              end else if (out_free) begin
                // square not finished: answer at once with the error status
                deq_o    = 1'b1;
                out_load = 1'b1;
                out_d    = '{cipher_a: '0, cipher_b: '0, status: 1'b1};
              end
            end
            default: deq_o = 1'b1;
          endcase
        end
      end
      S_FILL: begin
        place_chr = fill_ltr_q;
        place_en  = (fill_ltr_q != CodeJ);
        if (fill_ltr_q == CodeZ) begin
          ready_d = 1'b1;
          st_d    = S_IDLE;
        end else begin
          fill_ltr_d = fill_ltr_q + LetterW'(1);
        end
      end
      S_POS: begin
        sq_rd = 1'b1;
        st_d  = S_SQ;
      end
      S_SQ: begin
        if (out_free) begin
          out_load = 1'b1;
          st_d     = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  // placement bookkeeping: next free cell walks row-major
  always_comb begin
    used_d = used_q;
    fill_d = fill_q;
    row_d  = row_q;
    col_d  = col_q;
    if (place_ok) begin
      used_d[place_chr] = 1'b1;
      fill_d = fill_q + LetterW'(1);
      if (col_q == RcLast) begin
        col_d = '0;
        row_d = row_q + RcW'(1);
      end else begin
        col_d = col_q + RcW'(1);
      end
    end
  end

  // digraph rules on the looked-up positions
  always_comb begin
    if (pa_q.row == pb_q.row) begin
      oa = cell_idx(pa_q.row, rc_next(pa_q.col));
      ob = cell_idx(pb_q.row, rc_next(pb_q.col));
    end else if (pa_q.col == pb_q.col) begin
      oa = cell_idx(rc_next(pa_q.row), pa_q.col);
      ob = cell_idx(rc_next(pb_q.row), pb_q.col);
    end else begin
      oa = cell_idx(pa_q.row, pb_q.col);
      ob = cell_idx(pb_q.row, pa_q.col);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) out_valid_d = 1'b1;
    else if (pop) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      used_q      <= '0;
      fill_q      <= '0;
      row_q       <= '0;
      col_q       <= '0;
      fill_ltr_q  <= '0;
      ready_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      used_q      <= used_d;
      fill_q      <= fill_d;
      row_q       <= row_d;
      col_q       <= col_d;
      fill_ltr_q  <= fill_ltr_d;
      ready_q     <= ready_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) rsp_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (place_ok) pos_mem[place_chr] <= cur_pos;
    if (pos_rd) begin
      pa_q <= pos_mem[head_i.cmd.a];
      pb_q <= pos_mem[head_i.cmd.b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (place_ok) sq_mem[fill_q] <= place_chr;
    if (sq_rd) begin
      sqa_q <= sq_mem[oa];
      sqb_q <= sq_mem[ob];
    end
  end

  assign empty = !out_valid_q;
  assign rsp_o = rsp_q;

endmodule

>>> rtl/pfc_checker.sv
// Port-level checks for the Playfair digraph cipher, bound to the top level.
`timescale 1ns / 1ps

module pfc_checker import pfc_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     empty,
  input logic     pop,
  input out_rsp_t rsp_o
);

  // no result survives reset
  assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result visible during reset");

  // a waiting result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(rsp_o)))
    else $error("result changed or vanished while stalled");

  // results leave only through pop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(empty) |-> $past(pop))
    else $error("result dropped without pop");

  // error responses carry zero letters
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && rsp_o.status) |-> (rsp_o.cipher_a == '0 && rsp_o.cipher_b == '0))
    else $error("error response with nonzero letters");

  // good responses only carry letters that can sit in the square
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !rsp_o.status) |->
      (rsp_o.cipher_a <= CodeZ && rsp_o.cipher_a != CodeJ &&
       rsp_o.cipher_b <= CodeZ && rsp_o.cipher_b != CodeJ))
    else $error("cipher letter outside the square alphabet");

endmodule

bind playfair_digraph_cipher pfc_checker u_pfc_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .empty  (empty),
  .pop    (pop),
  .rsp_o  (rsp_o)
);

>>> tb/playfair_digraph_cipher_tb.sv
// Testbench for the Playfair digraph cipher: directed table, random digraphs, scoreboard.
`timescale 1ns / 1ps

module playfair_digraph_cipher_tb;
  import pfc_pkg::*;

  localparam logic [1:0]  KindUnused = 2'd3;
  localparam int unsigned NumItems    = 1075;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned MaxShown    = 10;
  localparam int unsigned QuietFrom   = 2000;
  localparam int unsigned QuietTo     = 3500;
  localparam int unsigned HoldAfter   = 200;
  localparam int unsigned HoldCycles  = 300;

  typedef struct packed {
    in_req_t  req;
    bit       fixed;
    out_rsp_t rsp;
  } dir_row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     push;
  logic     full;
  in_req_t  req_i;
  logic     empty;
  logic     pop;
  out_rsp_t rsp_o;

  playfair_digraph_cipher u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push  (push),
    .full  (full),
    .req_i (req_i),
    .empty (empty),
    .pop   (pop),
    .rsp_o (rsp_o)
  );

  always #4 clk_i = ~clk_i;

  int unsigned cycle_cnt = 0;
  int unsigned fail_cnt  = 0;
  int unsigned rsp_seen  = 0;
  bit          rsp_hold  = 1'b0;
  out_rsp_t    cipher_q [$];
  dir_row_t    dir_tab [$];

  // shadow copy of the key square
  logic [LetterW-1:0] key_cell [SqCells];
  logic [LetterW-1:0] key_pos  [NumLetters];
  logic [NumLetters-1:0] key_used = '0;
  int unsigned        key_fill = 0;
  bit                 key_done = 1'b0;

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  function automatic bit quiet();
    return cycle_cnt >= QuietFrom && cycle_cnt < QuietTo;
  endfunction

  function automatic logic [LetterW-1:0] ltr(input byte ch);
    return LetterW'(ch - 8'd65);
  endfunction

  function automatic logic [LetterW-1:0] rand_letter();
    if ($urandom_range(0, 9) == 0) return LetterW'($urandom_range(26, 31));
    return LetterW'($urandom_range(0, 25));
  endfunction

  function automatic logic [LetterW-1:0] fold_letter(input logic [LetterW-1:0] v);
    logic [LetterW-1:0] c;
    c = (v > CodeZ) ? CodeZ : v;
    return (c == CodeJ) ? CodeI : c;
  endfunction

  function automatic void place_letter(input logic [LetterW-1:0] c);
    if (key_fill < SqCells && !key_used[c]) begin
      key_cell[key_fill] = c;
      key_pos[c]         = LetterW'(key_fill);
      key_used[c]        = 1'b1;
      key_fill++;
    end
  endfunction

  // updates the shadow square; returns 1 when the request yields a result
  function automatic bit predict_cipher(input in_req_t r, output out_rsp_t rsp);
    int unsigned n, pa, pb, ra, ca, rb, cb, oa, ob;
    rsp = '0;
    case (r.kind)
      KindKey: begin
        if (!key_done) place_letter(fold_letter(r.letter_a));
        return 1'b0;
      end
      KindFinish: begin
        if (!key_done) begin
          for (n = 0; n < NumLetters; n++)
            if (LetterW'(n) != CodeJ) place_letter(LetterW'(n));
          key_done = 1'b1;
        end
        return 1'b0;
      end
      KindDigraph: begin
        if (!key_done) begin
          rsp.status = 1'b1;
          return 1'b1;
        end
        pa = key_pos[fold_letter(r.letter_a)];
        pb = key_pos[fold_letter(r.letter_b)];
        ra = pa / SqSide;
        ca = pa % SqSide;
        rb = pb / SqSide;
        cb = pb % SqSide;
        if (ra == rb) begin
          oa = ra * SqSide + (ca + 1) % SqSide;
          ob = rb * SqSide + (cb + 1) % SqSide;
        end else if (ca == cb) begin
          oa = ((ra + 1) % SqSide) * SqSide + ca;
          ob = ((rb + 1) % SqSide) * SqSide + cb;
        end else begin
          oa = ra * SqSide + cb;
          ob = rb * SqSide + ca;
        end
        rsp.cipher_a = key_cell[oa];
        rsp.cipher_b = key_cell[ob];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic dir_row_t dr(input logic [1:0] k, input logic [LetterW-1:0] a,
                                  input logic [LetterW-1:0] b);
    dir_row_t row;
    row.req.kind     = k;
    row.req.letter_a = a;
    row.req.letter_b = b;
    row.fixed        = 1'b0;
    row.rsp          = '0;
    return row;
  endfunction

  // digraph before the square is finished: zero letters, status 1
  function automatic dir_row_t dr_early(input logic [LetterW-1:0] a,
                                        input logic [LetterW-1:0] b);
    dir_row_t row;
    row              = dr(KindDigraph, a, b);
    row.fixed        = 1'b1;
    row.rsp.cipher_a = 5'd0;
    row.rsp.cipher_b = 5'd0;
    row.rsp.status   = 1'b1;
    return row;
  endfunction

  task automatic check_rsp(input out_rsp_t got);
    out_rsp_t want;
    rsp_seen++;
    if (cipher_q.size() == 0) begin
      if (fail_cnt < MaxShown)
        $display("%0t: unexpected result a=%0d b=%0d status=%0d",
                 $realtime, got.cipher_a, got.cipher_b, got.status);
      fail_cnt++;
    end else begin
      want = cipher_q.pop_front();
      if (got.cipher_a !== want.cipher_a || got.cipher_b !== want.cipher_b ||
          got.status !== want.status) begin
        if (fail_cnt < MaxShown)
          $display("%0t: mismatch exp a=%0d b=%0d status=%0d got a=%0d b=%0d status=%0d",
                   $realtime, want.cipher_a, want.cipher_b, want.status,
                   got.cipher_a, got.cipher_b, got.status);
        fail_cnt++;
      end
    end
  endtask

  task automatic send_req(input in_req_t r, input bit fixed, input out_rsp_t fixed_rsp);
    bit       yields;
    out_rsp_t rsp;
    while (!quiet() && !rsp_hold && $urandom_range(0, 99) < 24) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push  <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (full);
    yields = predict_cipher(r, rsp);
    if (yields) cipher_q.push_back(fixed ? fixed_rsp : rsp);
  endtask

  initial begin : reset_gen
    rst_ni <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin : watchdog
    wait (cycle_cnt >= CycleLimit);
    $display("Verification failed");
    $finish;
  end

  initial begin : rsp_side
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held      = 1'b0;
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) check_rsp(rsp_o);
      // one long stall so the queue backs up into full
      if (!held && rsp_seen >= HoldAfter) begin
        held      = 1'b1;
        hold_left = HoldCycles;
      end
      rsp_hold <= hold_left != 0;
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= quiet() || $urandom_range(0, 99) >= 24;
      end
    end
  end

  initial begin : req_side
    in_req_t     r;
    int unsigned sent;
    push  <= 1'b0;
    req_i <= '0;

    // key PLAYFIEXZ: square rows PLAYF / IEXZB / CDGHK / MNOQR / STUVW
    dir_tab.push_back(dr_early(5'd0, 5'd25));
    dir_tab.push_back(dr_early(5'd31, 5'd31));
    dir_tab.push_back(dr(KindKey, ltr("P"), 5'd0));
    dir_tab.push_back(dr(KindKey, ltr("L"), 5'd0));
    dir_tab.push_back(dr(KindKey, ltr("A"), 5'd0));
    dir_tab.push_back(dr(KindKey, ltr("Y"), 5'd0));
    dir_tab.push_back(dr(KindKey, ltr("F"), 5'd0));
    dir_tab.push_back(dr(KindKey, ltr("J"), 5'd31));
    dir_tab.push_back(dr(KindKey, ltr("E"), 5'd0));
    dir_tab.push_back(dr(KindKey, ltr("X"), 5'd0));
    dir_tab.push_back(dr(KindKey, ltr("A"), 5'd0));
    dir_tab.push_back(dr(KindKey, ltr("I"), 5'd0));
    dir_tab.push_back(dr(KindKey, 5'd31, 5'd0));
    dir_tab.push_back(dr(KindUnused, 5'd31, 5'd31));
    dir_tab.push_back(dr(KindKey, 5'd26, 5'd0));
    dir_tab.push_back(dr(KindFinish, 5'd0, 5'd0));
    dir_tab.push_back(dr(KindFinish, 5'd0, 5'd0));
    dir_tab.push_back(dr(KindKey, ltr("B"), 5'd0));
    dir_tab.push_back(dr(KindDigraph, ltr("P"), ltr("F")));
    dir_tab.push_back(dr(KindDigraph, ltr("P"), ltr("S")));
    dir_tab.push_back(dr(KindDigraph, ltr("A"), ltr("Z")));
    dir_tab.push_back(dr(KindDigraph, ltr("L"), ltr("L")));
    dir_tab.push_back(dr(KindDigraph, ltr("J"), ltr("E")));
    dir_tab.push_back(dr(KindDigraph, 5'd30, ltr("A")));
    dir_tab.push_back(dr(KindDigraph, ltr("W"), ltr("S")));

    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    foreach (dir_tab[i]) send_req(dir_tab[i].req, dir_tab[i].fixed, dir_tab[i].rsp);

    // square is fixed from here on: mostly digraphs, a few ignored requests
    sent = 0;
    while (sent < NumItems) begin
      r.letter_a = rand_letter();
      r.letter_b = ($urandom_range(0, 15) == 0) ? r.letter_a : rand_letter();
      case ($urandom_range(0, 19))
        0:       r.kind = KindKey;
        1:       r.kind = KindFinish;
        2:       r.kind = KindUnused;
        default: r.kind = KindDigraph;
      endcase
      sent++;
      send_req(r, 1'b0, '0);
    end
    push <= 1'b0;

    while (cipher_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (cipher_q.size() != 0) fail_cnt++;

    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
